// ===== design/pcl_pkg.sv =====
package pcl_pkg;

  // Field widths fixed by the item format
  localparam int CH_W    = 4;
  localparam int SUB_W   = 2;
  localparam int VAL_W   = 16;
  localparam int GEN_W   = 2;
  localparam int PCT_W   = 7;
  localparam int SCALE_W = 24;
  localparam int SCALE_SHIFT = 23;

  // Default channel count, full-scale percentage
  localparam int PCL_NUM_CHANNELS = 16;
  localparam int PCT_FULL = 100;

  typedef enum logic [1:0] {
    ACT_SET_THRESH = 2'd0,
    ACT_SET_LOAD   = 2'd1,
    ACT_RAW_CMP    = 2'd2,
    ACT_PCT_CMP    = 2'd3
  } pcl_action_t;

  typedef struct packed {
    pcl_action_t        action;
    logic [CH_W-1:0]    channel;
    logic [SUB_W-1:0]   sub_channel;
    logic [VAL_W-1:0]   value;
    logic [VAL_W-1:0]   value_high;
  } pcl_in_t;

  typedef struct packed {
    logic               write_valid;
    logic               module_sel;
    logic [GEN_W-1:0]   generator_sel;
    logic               target_b;
    logic [VAL_W-1:0]   compare_out;
    logic               error_flag;
  } pcl_out_t;

  // Table write request from the top level to the channel table
  typedef struct packed {
    logic               wr_thresh;
    logic               wr_load;
    logic [CH_W-1:0]    channel;
    logic [VAL_W-1:0]   value;
    logic [VAL_W-1:0]   value_high;
  } pcl_tbl_wr_t;

  // Per-channel limits read back from the table
  typedef struct packed {
    logic [VAL_W-1:0]   low;
    logic [VAL_W-1:0]   high;
    logic [VAL_W-1:0]   load;
  } pcl_limits_t;

  // Scale factors ceil(p * 2^23 / 100) for p = 0..100, packed entry p at [p*24 +: 24].
  // floor(x * factor >> 23) equals floor(x * p / 100) for any 16-bit x.
  function automatic logic [(PCT_FULL+1)*SCALE_W-1:0] build_scale();
    logic [(PCT_FULL+1)*SCALE_W-1:0] tbl;
    longint                          num;
    tbl = '0;
    for (int p = 0; p <= PCT_FULL; p++) begin
      num = (longint'(p) << SCALE_SHIFT) + longint'(PCT_FULL - 1);
      tbl[p*SCALE_W +: SCALE_W] = SCALE_W'(num / PCT_FULL);
    end
    return tbl;
  endfunction

  localparam logic [(PCT_FULL+1)*SCALE_W-1:0] PCT_SCALE_TBL = build_scale();

endpackage

// ===== design/pcl_table.sv =====
module pcl_table
  import pcl_pkg::*;
#(
  parameter int NUM_CHANNELS = PCL_NUM_CHANNELS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pcl_tbl_wr_t       wr,
  input  logic [CH_W-1:0]   rd_channel,
  output pcl_limits_t       rd_limits
);

  // Only channels reachable by the 4-bit channel field get storage
  localparam int DEPTH = (NUM_CHANNELS < (1 << CH_W)) ? NUM_CHANNELS : (1 << CH_W);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [VAL_W-1:0] low_r  [DEPTH];
  logic [VAL_W-1:0] high_r [DEPTH];
  logic [VAL_W-1:0] load_r [DEPTH];

  logic             wr_in_range;
  logic             rd_in_range;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;

  assign wr_in_range = {3'b000, wr.channel} < 7'(NUM_CHANNELS);
  assign rd_in_range = {3'b000, rd_channel} < 7'(NUM_CHANNELS);
  assign wr_idx      = wr.channel[IDX_W-1:0];
  assign rd_idx      = rd_channel[IDX_W-1:0];

  // Threshold and load storage, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        low_r[i]  <= '0;
        high_r[i] <= '0;
        load_r[i] <= '0;
      end
    end else if (wr_in_range) begin
      if (wr.wr_thresh) begin
        low_r[wr_idx]  <= wr.value;
        high_r[wr_idx] <= wr.value_high;
      end
      if (wr.wr_load) begin
        load_r[wr_idx] <= wr.value;
      end
    end
  end

  // Out-of-range channels read as all zeros
  always_comb begin
    if (rd_in_range) begin
      rd_limits.low  = low_r[rd_idx];
      rd_limits.high = high_r[rd_idx];
      rd_limits.load = load_r[rd_idx];
    end else begin
      rd_limits = '0;
    end
  end

endmodule

// ===== design/pcl_calc.sv =====
module pcl_calc
  import pcl_pkg::*;
(
  input  pcl_in_t      item,
  input  pcl_limits_t  lim,
  output pcl_out_t     res
);

  logic                     is_cmp;
  logic                     raw_err;
  logic [VAL_W-1:0]         raw_val;
  logic                     pct_over;
  logic [PCT_W-1:0]         pct;
  logic                     hi_set;
  logic [VAL_W-1:0]         diff;
  logic [VAL_W-1:0]         base;
  logic [SCALE_W-1:0]       scale;
  logic [VAL_W+SCALE_W-1:0] prod;
  logic [VAL_W-1:0]         frac;
  logic [VAL_W-1:0]         pct_val;

  assign is_cmp = (item.action == ACT_RAW_CMP) || (item.action == ACT_PCT_CMP);
  assign hi_set = lim.high != '0;

  // Raw clamp: high (when set), then low, then load
  always_comb begin
    raw_val = item.value;
    raw_err = 1'b0;
    if (hi_set && (item.value > lim.high)) begin
      raw_val = lim.high;
      raw_err = 1'b1;
    end else if (item.value < lim.low) begin
      raw_val = lim.low;
      raw_err = 1'b1;
    end else if (item.value > lim.load) begin
      raw_val = lim.load;
      raw_err = 1'b1;
    end
  end

  // Percentage saturation
  assign pct_over = item.value > VAL_W'(PCT_FULL);
  assign pct      = pct_over ? PCT_W'(PCT_FULL) : item.value[PCT_W-1:0];

  // Window width, zero when low is above high
  assign diff = (lim.high > lim.low) ? (lim.high - lim.low) : '0;
  assign base = hi_set ? diff : lim.load;

  // base * pct / 100 through the reciprocal table, one multiply
  assign scale   = PCT_SCALE_TBL[pct*SCALE_W +: SCALE_W];
  assign prod    = (VAL_W+SCALE_W)'(base) * (VAL_W+SCALE_W)'(scale);
  assign frac    = prod[SCALE_SHIFT +: VAL_W];
  assign pct_val = hi_set ? (lim.low + frac) : frac;

  // Set actions give an all-zero result
  always_comb begin
    res = '0;
    if (is_cmp) begin
      res.write_valid   = 1'b1;
      res.module_sel    = item.channel[CH_W-1];
      res.generator_sel = item.channel[GEN_W:1];
      res.target_b      = item.sub_channel[0];
      if (item.action == ACT_RAW_CMP) begin
        res.compare_out = raw_val;
        res.error_flag  = raw_err;
      end else begin
        res.compare_out = pct_val;
        res.error_flag  = pct_over;
      end
    end
  end

endmodule

// ===== design/pwm_compare_limiter.sv =====
// Channel   Direction  Ports                          Payload
// in        input      in_valid, in_stall, in_item    pcl_in_t
// out       output     out_valid, out_stall, out_item pcl_out_t
//
// One item per cycle while the output is not stalled; each item gives exactly one result,
// which passes through the input register, then the result register.
// Table writes and reads both happen from the input register, so a compare right after
// a set sees the new thresholds.
// Synchronous active-low reset empties both stages and zeroes every channel table.
// A stalled output holds both stages; in_stall rises only while the input register is full.
module pwm_compare_limiter
  import pcl_pkg::*;
#(
  parameter int NUM_CHANNELS = PCL_NUM_CHANNELS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  pcl_in_t  in_item,
  output logic     out_valid,
  input  logic     out_stall,
  output pcl_out_t out_item
);

  logic        in_valid_r;
  pcl_in_t     in_item_r;
  logic        out_valid_r;
  pcl_out_t    out_item_r;
  logic        advance;
  pcl_tbl_wr_t tbl_wr;
  pcl_limits_t limits;
  pcl_out_t    result;

  // Pipeline moves when the result register is free or being taken
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !advance;

  // Table update as the item leaves the input register
  always_comb begin
    tbl_wr            = '0;
    tbl_wr.channel    = in_item_r.channel;
    tbl_wr.value      = in_item_r.value;
    tbl_wr.value_high = in_item_r.value_high;
    if (in_valid_r && advance) begin
      tbl_wr.wr_thresh = in_item_r.action == ACT_SET_THRESH;
      tbl_wr.wr_load   = in_item_r.action == ACT_SET_LOAD;
    end
  end

  pcl_table #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (tbl_wr),
    .rd_channel (in_item_r.channel),
    .rd_limits  (limits)
  );

  pcl_calc u_calc (
    .item (in_item_r),
    .lim  (limits),
    .res  (result)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_item;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== test/pwm_compare_limiter_test.sv =====
module pwm_compare_limiter_test;
  import pcl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_PER_PHASE = 375;
  localparam int DIR_COUNT = 23;

  // One directed row: item, whether the result is typed in, and that result
  typedef struct packed {
    pcl_in_t  item;
    logic     typed;
    pcl_out_t want;
  } dir_row_t;

  logic     clk;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  pcl_in_t  in_item = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  pcl_out_t out_item;

  // Per-channel limits as the block should hold them
  logic [VAL_W-1:0] thresh_lo [PCL_NUM_CHANNELS];
  logic [VAL_W-1:0] thresh_hi [PCL_NUM_CHANNELS];
  logic [VAL_W-1:0] load_val  [PCL_NUM_CHANNELS];

  pcl_out_t pending_writes [$];
  int       mismatch_count = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;

  // Columns: action, channel, sub, value, value_high | typed | wv, mod, gen, b, compare, err
  dir_row_t dir_rows [0:DIR_COUNT-1] = '{
    // tables empty after reset: everything clamps to a zero load
    {ACT_RAW_CMP,    4'd0,  2'd0, 16'hFFFF, 16'h0000, 1'b1, 1'b1, 1'b0, 2'd0, 1'b0, 16'd0, 1'b1},
    {ACT_PCT_CMP,    4'd15, 2'd1, 16'd100,  16'hFFFF, 1'b1, 1'b1, 1'b1, 2'd3, 1'b1, 16'd0, 1'b0},
    {ACT_PCT_CMP,    4'd9,  2'd3, 16'hFFFF, 16'h0000, 1'b1, 1'b1, 1'b1, 2'd0, 1'b1, 16'd0, 1'b1},
    {ACT_SET_THRESH, 4'd0,  2'd0, 16'd100,  16'd1000, 1'b1, 1'b0, 1'b0, 2'd0, 1'b0, 16'd0, 1'b0},
    {ACT_SET_LOAD,   4'd0,  2'd2, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0, 2'd0, 1'b0, 16'd0, 1'b0},
    // window 100..1000 on channel 0
    {ACT_RAW_CMP,    4'd0,  2'd0, 16'd5000, 16'h0000, 1'b1, 1'b1, 1'b0, 2'd0, 1'b0, 16'd1000, 1'b1},
    {ACT_RAW_CMP,    4'd0,  2'd0, 16'd10,   16'h0000, 1'b1, 1'b1, 1'b0, 2'd0, 1'b0, 16'd100, 1'b1},
    {ACT_RAW_CMP,    4'd0,  2'd1, 16'd500,  16'h0000, 1'b0, 22'h0},
    {ACT_PCT_CMP,    4'd0,  2'd0, 16'd50,   16'h0000, 1'b0, 22'h0},
    {ACT_PCT_CMP,    4'd0,  2'd0, 16'd101,  16'h0000, 1'b1, 1'b1, 1'b0, 2'd0, 1'b0, 16'd1000, 1'b1},
    // window pinned at 0xFFFF (low equals high) but zero load
    {ACT_SET_THRESH, 4'd5,  2'd0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0, 2'd0, 1'b0, 16'd0, 1'b0},
    {ACT_RAW_CMP,    4'd5,  2'd2, 16'hFFFF, 16'h0000, 1'b1, 1'b1, 1'b0, 2'd2, 1'b0, 16'd0, 1'b1},
    // low above high
    {ACT_SET_THRESH, 4'd6,  2'd0, 16'd2000, 16'd1000, 1'b1, 1'b0, 1'b0, 2'd0, 1'b0, 16'd0, 1'b0},
    {ACT_PCT_CMP,    4'd6,  2'd1, 16'd77,   16'h0000, 1'b0, 22'h0},
    // no upper limit, full load
    {ACT_SET_LOAD,   4'd7,  2'd0, 16'hFFFF, 16'h0000, 1'b1, 1'b0, 1'b0, 2'd0, 1'b0, 16'd0, 1'b0},
    {ACT_RAW_CMP,    4'd7,  2'd0, 16'hFFFF, 16'h0000, 1'b0, 22'h0},
    {ACT_PCT_CMP,    4'd7,  2'd1, 16'd99,   16'h0000, 1'b0, 22'h0},
    {ACT_PCT_CMP,    4'd7,  2'd0, 16'd0,    16'h0000, 1'b0, 22'h0},
    {ACT_SET_THRESH, 4'd12, 2'd0, 16'd0,    16'hFFFF, 1'b1, 1'b0, 1'b0, 2'd0, 1'b0, 16'd0, 1'b0},
    {ACT_SET_LOAD,   4'd12, 2'd0, 16'hFFFF, 16'h0000, 1'b1, 1'b0, 1'b0, 2'd0, 1'b0, 16'd0, 1'b0},
    {ACT_PCT_CMP,    4'd12, 2'd2, 16'd33,   16'h0000, 1'b0, 22'h0},
    {ACT_RAW_CMP,    4'd12, 2'd3, 16'h1234, 16'h0000, 1'b0, 22'h0},
    // untouched channel in module 1, nothing to clamp
    {ACT_RAW_CMP,    4'd8,  2'd0, 16'd0,    16'h0000, 1'b1, 1'b1, 1'b1, 2'd0, 1'b0, 16'd0, 1'b0}
  };

  pwm_compare_limiter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Update the limit tables and work out the compare write an item gives
  function automatic pcl_out_t compute_write(input pcl_in_t it);
    pcl_out_t    r;
    logic        known;
    int unsigned lo, hi, ld, pct, diff, res;
    r = '0;
    known = int'(it.channel) < PCL_NUM_CHANNELS;
    lo = known ? 32'(thresh_lo[it.channel]) : 32'd0;
    hi = known ? 32'(thresh_hi[it.channel]) : 32'd0;
    ld = known ? 32'(load_val[it.channel]) : 32'd0;
    case (it.action)
      ACT_SET_THRESH: begin
        if (known) begin
          thresh_lo[it.channel] = it.value;
          thresh_hi[it.channel] = it.value_high;
        end
      end
      ACT_SET_LOAD: begin
        if (known)
          load_val[it.channel] = it.value;
      end
      default: begin
        res = 32'(it.value);
        if (it.action == ACT_RAW_CMP) begin
          // clamp order: high (if set), then low, then load
          if (hi != 0 && res > hi) begin
            res = hi;
            r.error_flag = 1'b1;
          end else if (res < lo) begin
            res = lo;
            r.error_flag = 1'b1;
          end else if (res > ld) begin
            res = ld;
            r.error_flag = 1'b1;
          end
        end else begin
          pct = 32'(it.value);
          if (pct > PCT_FULL) begin
            pct = PCT_FULL;
            r.error_flag = 1'b1;
          end
          if (hi != 0) begin
            diff = (hi > lo) ? hi - lo : 0;
            res = lo + (diff * pct) / PCT_FULL;
          end else begin
            res = (ld * pct) / PCT_FULL;
          end
        end
        r.write_valid   = 1'b1;
        r.module_sel    = it.channel[3];
        r.generator_sel = it.channel[2:1];
        r.target_b      = it.sub_channel[0];
        r.compare_out   = res[VAL_W-1:0];
      end
    endcase
    return r;
  endfunction

  // Random item, biased toward the edges of the current channel limits
  function automatic pcl_in_t rand_item();
    pcl_in_t     it;
    int unsigned pick, a, b;
    int          near;
    it.channel     = CH_W'($urandom_range(15));
    it.sub_channel = SUB_W'($urandom_range(3));
    it.value_high  = VAL_W'($urandom_range(65535));
    it.value       = VAL_W'($urandom_range(65535));
    pick = $urandom_range(99);
    if (pick < 15) begin
      it.action = ACT_SET_THRESH;
      case ($urandom_range(9))
        0: it.value_high = '0;
        1: begin
          a = $urandom_range(65535);
          b = $urandom_range(65535);
          it.value      = VAL_W'((a > b) ? a : b);
          it.value_high = VAL_W'((a > b) ? b : a);
        end
        2: begin
          it.value      = '0;
          it.value_high = '1;
        end
        default: begin
          it.value      = VAL_W'($urandom_range(32767));
          it.value_high = VAL_W'($urandom_range(65535, 32'(it.value)));
        end
      endcase
    end else if (pick < 25) begin
      it.action = ACT_SET_LOAD;
      case ($urandom_range(9))
        0: it.value = '0;
        1: it.value = '1;
        default: ;
      endcase
    end else if (pick < 60) begin
      it.action = ACT_RAW_CMP;
      if ($urandom_range(1) == 0) begin
        case ($urandom_range(2))
          0: near = int'(thresh_lo[it.channel]);
          1: near = int'(thresh_hi[it.channel]);
          default: near = int'(load_val[it.channel]);
        endcase
        near = near + int'($urandom_range(4)) - 2;
        it.value = near[VAL_W-1:0];
      end
    end else begin
      it.action = ACT_PCT_CMP;
      case ($urandom_range(9))
        0: it.value = VAL_W'($urandom_range(200, 101));
        1: ;
        default: it.value = VAL_W'($urandom_range(PCT_FULL));
      endcase
    end
    return it;
  endfunction

  // Offer one item with random idle gaps; record its write once accepted
  task automatic send_item(input pcl_in_t it, input logic typed, input pcl_out_t want);
    pcl_out_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    predicted = compute_write(it);
    pending_writes.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic check_write(input pcl_out_t got);
    pcl_out_t want;
    if (pending_writes.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected result: item=%h", got);
      return;
    end
    want = pending_writes.pop_front();
    if (got.write_valid !== want.write_valid || got.module_sel !== want.module_sel ||
        got.generator_sel !== want.generator_sel || got.target_b !== want.target_b ||
        got.compare_out !== want.compare_out || got.error_flag !== want.error_flag) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("result mismatch: expected wv=%b mod=%b gen=%0d b=%b cmp=%h err=%b",
                 want.write_valid, want.module_sel, want.generator_sel, want.target_b,
                 want.compare_out, want.error_flag);
        $display("                 got      wv=%b mod=%b gen=%0d b=%b cmp=%h err=%b",
                 got.write_valid, got.module_sel, got.generator_sel, got.target_b,
                 got.compare_out, got.error_flag);
      end
    end
  endtask

  // Result side: random stall, checked at the rising edge
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      check_write(out_item);
  end

  // Stimulus: reset, directed rows, then random items over four idling phases
  initial begin
    for (int c = 0; c < PCL_NUM_CHANNELS; c++) begin
      thresh_lo[c] = '0;
      thresh_hi[c] = '0;
      load_val[c]  = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      if (ph == 0) begin
        for (int k = 0; k < DIR_COUNT; k++)
          send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
      end
      for (int k = 0; k < RAND_PER_PHASE; k++)
        send_item(rand_item(), 1'b0, '0);
    end
    in_valid <= 1'b0;
    while (pending_writes.size() != 0)
      @(posedge clk);
    // catch any stray result after the last one
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== pwm_compare_limiter.f =====
design/pcl_pkg.sv
design/pcl_table.sv
design/pcl_calc.sv
design/pwm_compare_limiter.sv
test/pwm_compare_limiter_test.sv
